// ----- design/qat_pkg.sv -----
// Package of the quoted argument tokenizer: types, character codes and widths.
// No dependencies; every other design file imports it.
package qat_pkg;

    localparam int COUNT_W = 7;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_S      = 8'h73;
    localparam logic [BYTE_W-1:0] CHAR_T      = 8'h74;

    typedef enum logic [1:0] {
        LEX_IDLE   = 2'd0,
        LEX_PLAIN  = 2'd1,
        LEX_QUOTED = 2'd2,
        LEX_ESCAPE = 2'd3
    } t_lex_state;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               arg_end;
        logic               line_end;
        logic [COUNT_W-1:0] arg_count;
        logic               overflow;
    } t_result;

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

// ----- design/qat_in_stage.sv -----
// Input register of the tokenizer: holds one accepted byte until it is processed.
// Depends on qat_pkg.
module qat_in_stage
    import qat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_advance,
    output logic              o_full,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_full;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_full || i_advance;
    assign o_full  = r_full;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_in_byte;
        end
    end

endmodule

// ----- design/qat_lex.sv -----
// Lexer state and per-byte step logic of the tokenizer.
// Depends on qat_pkg.
module qat_lex
    import qat_pkg::*;
#(
    parameter logic [COUNT_W-1:0] CAP = 7'd64
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_emit,
    output t_result           o_result
);

    t_lex_state         r_state;
    t_lex_state         n_state;
    logic [COUNT_W-1:0] r_closed;
    logic [COUNT_W-1:0] n_closed;
    logic               r_drop;
    logic               n_drop;

    logic               eol;
    logic               blank;
    logic               dropped;
    logic               closing;
    logic [COUNT_W-1:0] cl_closed;
    logic               cl_drop;
    logic [BYTE_W-1:0]  xlat_byte;

    assign eol     = (i_byte == CHAR_NUL);
    assign blank   = is_blank(i_byte);
    assign dropped = (r_closed >= CAP);

    always_comb begin
        unique case (r_state)
            LEX_IDLE:   closing = eol;
            LEX_PLAIN:  closing = eol || blank;
            LEX_QUOTED: closing = eol || (i_byte == CHAR_QUOTE);
            LEX_ESCAPE: closing = eol;
            default:    closing = 1'b0;
        endcase
        if (r_state == LEX_IDLE) begin
            closing = 1'b0;
        end
    end

    assign cl_closed = (closing && !dropped) ? r_closed + 7'd1 : r_closed;
    assign cl_drop   = r_drop || (closing && dropped);

    always_comb begin
        n_state  = r_state;
        n_closed = cl_closed;
        n_drop   = cl_drop;
        if (eol) begin
            n_state  = LEX_IDLE;
            n_closed = '0;
            n_drop   = 1'b0;
        end else begin
            unique case (r_state)
                LEX_IDLE: begin
                    if (i_byte == CHAR_QUOTE) begin
                        n_state = LEX_QUOTED;
                    end else if (!blank) begin
                        n_state = LEX_PLAIN;
                    end
                end
                LEX_PLAIN: begin
                    if (blank) begin
                        n_state = LEX_IDLE;
                    end
                end
                LEX_QUOTED: begin
                    if (i_byte == CHAR_BSLASH) begin
                        n_state = LEX_ESCAPE;
                    end else if (i_byte == CHAR_QUOTE) begin
                        n_state = LEX_IDLE;
                    end
                end
                LEX_ESCAPE: n_state = LEX_QUOTED;
                default:    n_state = LEX_IDLE;
            endcase
        end
    end

    always_comb begin
        priority if (i_byte == CHAR_S) begin
            xlat_byte = CHAR_SPACE;
        end else if (i_byte == CHAR_T) begin
            xlat_byte = CHAR_TAB;
        end else begin
            xlat_byte = i_byte;
        end
    end

    always_comb begin
        o_result.out_byte  = CHAR_NUL;
        o_result.arg_end   = 1'b0;
        o_result.line_end  = 1'b0;
        o_result.arg_count = cl_closed;
        o_result.overflow  = cl_drop;
        o_emit             = 1'b0;
        if (eol) begin
            o_emit            = 1'b1;
            o_result.line_end = 1'b1;
            o_result.arg_end  = closing && !dropped;
        end else begin
            unique case (r_state)
                LEX_IDLE: begin
                    if (!blank && (i_byte != CHAR_QUOTE) && !dropped) begin
                        o_emit            = 1'b1;
                        o_result.out_byte = i_byte;
                    end
                end
                LEX_PLAIN: begin
                    if (!dropped) begin
                        o_emit = 1'b1;
                        if (blank) begin
                            o_result.arg_end = 1'b1;
                        end else begin
                            o_result.out_byte = i_byte;
                        end
                    end
                end
                LEX_QUOTED: begin
                    if (!dropped && (i_byte != CHAR_BSLASH)) begin
                        o_emit = 1'b1;
                        if (i_byte == CHAR_QUOTE) begin
                            o_result.arg_end = 1'b1;
                        end else begin
                            o_result.out_byte = i_byte;
                        end
                    end
                end
                LEX_ESCAPE: begin
                    if (!dropped) begin
                        o_emit            = 1'b1;
                        o_result.out_byte = xlat_byte;
                    end
                end
                default: o_emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= LEX_IDLE;
            r_closed <= '0;
            r_drop   <= 1'b0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_closed <= n_closed;
            r_drop   <= n_drop;
        end
    end

endmodule

// ----- design/qat_out_stage.sv -----
// Result register of the tokenizer: holds one result item until it is taken.
// Depends on qat_pkg.
module qat_out_stage
    import qat_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- design/quoted_argument_tokenizer.sv -----
// Quoted argument tokenizer: one line byte per item, argument bytes and marks out.
// One item per cycle while the result side is not stalled.
// Bytes pass the input register, then the result register; stalls pass back in-cycle.
// Synchronous active-low reset empties both registers and clears the lexer state.
// Depends on qat_pkg, qat_in_stage, qat_lex and qat_out_stage.
module quoted_argument_tokenizer
    import qat_pkg::*;
#(
    parameter int MAX_ARGS = 64
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_in_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_arg_end,
    output logic               o_line_end,
    output logic [COUNT_W-1:0] o_arg_count,
    output logic               o_overflow
);

    localparam int                 CAP_INT = (MAX_ARGS > 127) ? 127 : MAX_ARGS;
    localparam logic [COUNT_W-1:0] CAP     = COUNT_W'(CAP_INT);

    logic              advance;
    logic              in_full;
    logic [BYTE_W-1:0] in_byte;
    logic              step;
    logic              emit;
    t_result           lex_result;
    t_result           out_result;

    assign step = in_full && advance;

    qat_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_advance (advance),
        .o_full    (in_full),
        .o_byte    (in_byte)
    );

    qat_lex #(
        .CAP (CAP)
    ) u_lex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (in_byte),
        .o_emit   (emit),
        .o_result (lex_result)
    );

    qat_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && emit),
        .i_result   (lex_result),
        .o_can_load (advance),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_out_byte  = out_result.out_byte;
    assign o_arg_end   = out_result.arg_end;
    assign o_line_end  = out_result.line_end;
    assign o_arg_count = out_result.arg_count;
    assign o_overflow  = out_result.overflow;

endmodule

// ----- design/qat_checker.sv -----
// Port-level checker of the quoted argument tokenizer, bound to the top level.
// Depends on qat_pkg and quoted_argument_tokenizer.
module qat_checker
    import qat_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [BYTE_W-1:0]  o_out_byte,
    input logic               o_arg_end,
    input logic               o_line_end,
    input logic [COUNT_W-1:0] o_arg_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("Result item dropped before it was taken.");

    a_mark_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_arg_end || o_line_end) |-> (o_out_byte == CHAR_NUL))
        else $error("End mark carries a nonzero byte.");

    a_data_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_arg_end && !o_line_end |-> (o_out_byte != CHAR_NUL))
        else $error("Argument byte item carries a zero byte.");

    a_end_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_arg_end |-> (o_arg_count != '0))
        else $error("Closed argument not counted.");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_byte  (o_out_byte),
    .o_arg_end   (o_arg_end),
    .o_line_end  (o_line_end),
    .o_arg_count (o_arg_count)
);

// ----- tb/qat_token_checker.sv -----
// Token checker for the quoted argument tokenizer: watches both channels, predicts
// each line byte's result and compares it field by field. Depends on qat_pkg.
`timescale 1ns / 100ps

module qat_token_checker
    import qat_pkg::*;
#(
    parameter int MAX_ARGS = 64
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [BYTE_W-1:0]  i_in_byte,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [BYTE_W-1:0]  i_out_byte,
    input  logic               i_out_arg_end,
    input  logic               i_out_line_end,
    input  logic [COUNT_W-1:0] i_out_arg_count,
    input  logic               i_out_overflow,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_lines,
    output int                 o_capped_lines
);

    localparam int ARG_CAP = (MAX_ARGS > 127) ? 127 : MAX_ARGS;

    t_lex_state         lex_now;
    logic [COUNT_W-1:0] args_closed;
    logic               args_dropped;
    t_result            expected_tokens[$];
    int                 mismatch_total = 0;
    int                 result_total = 0;
    int                 line_total = 0;
    int                 capped_total = 0;

    assign o_mismatches   = mismatch_total;
    assign o_results      = result_total;
    assign o_lines        = line_total;
    assign o_capped_lines = capped_total;

    initial o_pending = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: token mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic bit is_separator(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit at_cap();
        return int'(args_closed) >= ARG_CAP;
    endfunction

    function automatic bit close_argument();
        lex_now = LEX_IDLE;
        if (at_cap()) begin
            args_dropped = 1'b1;
            return 1'b0;
        end
        args_closed = args_closed + 1'b1;
        return 1'b1;
    endfunction

    function automatic bit tokenize_byte(input logic [BYTE_W-1:0] c, output t_result r);
        bit               emit;
        logic [BYTE_W-1:0] b;
        r    = '0;
        emit = 1'b0;
        b    = c;
        if (c == CHAR_NUL) begin
            if (lex_now != LEX_IDLE) begin
                r.arg_end = close_argument();
            end
            r.line_end  = 1'b1;
            r.arg_count = args_closed;
            r.overflow  = args_dropped;
            lex_now      = LEX_IDLE;
            args_closed  = '0;
            args_dropped = 1'b0;
            return 1'b1;
        end
        case (lex_now)
            LEX_IDLE: begin
                if (is_separator(c)) begin
                    emit = 1'b0;
                end else if (c == CHAR_QUOTE) begin
                    lex_now = LEX_QUOTED;
                end else begin
                    lex_now = LEX_PLAIN;
                    emit    = !at_cap();
                end
            end
            LEX_PLAIN: begin
                if (is_separator(c)) begin
                    if (close_argument()) begin
                        r.arg_end = 1'b1;
                        b         = CHAR_NUL;
                        emit      = 1'b1;
                    end
                end else begin
                    emit = !at_cap();
                end
            end
            LEX_QUOTED: begin
                if (c == CHAR_BSLASH) begin
                    lex_now = LEX_ESCAPE;
                end else if (c == CHAR_QUOTE) begin
                    if (close_argument()) begin
                        r.arg_end = 1'b1;
                        b         = CHAR_NUL;
                        emit      = 1'b1;
                    end
                end else begin
                    emit = !at_cap();
                end
            end
            default: begin
                lex_now = LEX_QUOTED;
                if (c == CHAR_S) begin
                    b = CHAR_SPACE;
                end else if (c == CHAR_T) begin
                    b = CHAR_TAB;
                end
                emit = !at_cap();
            end
        endcase
        r.out_byte  = b;
        r.arg_count = args_closed;
        r.overflow  = args_dropped;
        return emit;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            lex_now      = LEX_IDLE;
            args_closed  = '0;
            args_dropped = 1'b0;
            expected_tokens.delete();
        end else begin
            // The result leaving now was caused by an earlier item, so compare first.
            if (i_out_valid && i_out_ready) begin
                got.out_byte  = i_out_byte;
                got.arg_end   = i_out_arg_end;
                got.line_end  = i_out_line_end;
                got.arg_count = i_out_arg_count;
                got.overflow  = i_out_overflow;
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("result %p with nothing expected", got));
                end else begin
                    want = expected_tokens.pop_front();
                    result_total++;
                    if (want.line_end) begin
                        line_total++;
                        if (want.overflow) begin
                            capped_total++;
                        end
                    end
                    if (got.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte expected %02h, got %02h",
                            want.out_byte, got.out_byte));
                    end
                    if (got.arg_end !== want.arg_end) begin
                        report_mismatch($sformatf("arg_end expected %0b, got %0b",
                            want.arg_end, got.arg_end));
                    end
                    if (got.line_end !== want.line_end) begin
                        report_mismatch($sformatf("line_end expected %0b, got %0b",
                            want.line_end, got.line_end));
                    end
                    if (got.arg_count !== want.arg_count) begin
                        report_mismatch($sformatf("arg_count expected %0d, got %0d",
                            want.arg_count, got.arg_count));
                    end
                    if (got.overflow !== want.overflow) begin
                        report_mismatch($sformatf("overflow expected %0b, got %0b",
                            want.overflow, got.overflow));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (tokenize_byte(i_in_byte, predicted)) begin
                    expected_tokens.push_back(predicted);
                end
            end
        end
        o_pending <= expected_tokens.size();
    end

endmodule

// ----- tb/quoted_argument_tokenizer_test.sv -----
// Testbench top for the quoted argument tokenizer: drives command line bytes and
// result stalls, and gives the verdict. Depends on qat_pkg, quoted_argument_tokenizer and qat_token_checker.
`timescale 1ns / 100ps

module quoted_argument_tokenizer_test;
    import qat_pkg::*;

    localparam int MAX_ARGS    = 64;
    localparam int ITEMS       = 1600;
    localparam int CALM_TAIL   = 250;
    localparam int STALL_LIMIT = 400;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [BYTE_W-1:0]  in_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_arg_end;
    logic               out_line_end;
    logic [COUNT_W-1:0] out_arg_count;
    logic               out_overflow;

    int mismatches;
    int pending;
    int results;
    int lines;
    int capped_lines;

    int               items_sent = 0;
    bit               idling_on = 1'b1;
    bit               sender_calm = 1'b0;
    logic [BYTE_W-1:0] line_bytes[$];

    wire in_taken  = in_valid && in_ready;
    wire out_taken = out_valid && out_ready;

    always #5 i_clk = ~i_clk;

    quoted_argument_tokenizer #(.MAX_ARGS(MAX_ARGS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_in_byte   (in_byte),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_out_byte  (out_byte),
        .o_arg_end   (out_arg_end),
        .o_line_end  (out_line_end),
        .o_arg_count (out_arg_count),
        .o_overflow  (out_overflow)
    );

    qat_token_checker #(.MAX_ARGS(MAX_ARGS)) u_token_checker (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_byte       (in_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_byte      (out_byte),
        .i_out_arg_end   (out_arg_end),
        .i_out_line_end  (out_line_end),
        .i_out_arg_count (out_arg_count),
        .i_out_overflow  (out_overflow),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_results       (results),
        .o_lines         (lines),
        .o_capped_lines  (capped_lines)
    );

    function automatic logic [BYTE_W-1:0] blank_byte();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CHAR_SPACE : CHAR_TAB + pick[BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] arg_byte(input bit first);
        logic [BYTE_W-1:0] c;
        do begin
            c = BYTE_W'($urandom_range(1, 255));
        end while (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR) ||
                   (first && c == CHAR_QUOTE));
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] c);
        if (idling_on && !sender_calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
        if (items_sent >= ITEMS - CALM_TAIL) begin
            idling_on = 1'b0;
        end
        @(negedge i_clk);
    endtask

    initial begin
        int cycle_count;
        bit receiver_calm;
        cycle_count   = 0;
        receiver_calm = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle_count++;
            if (cycle_count % 128 == 0) begin
                receiver_calm = ($urandom_range(0, 2) == 0);
            end
            if (idling_on && !receiver_calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if (in_taken || out_taken) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("Run stalled for %0d cycles with %0d results outstanding.", stalled, pending);
        $display("quoted_argument_tokenizer_test: FAIL");
        $finish;
    end

    initial begin
        int n_args;
        int max_len;
        int cut;
        logic [BYTE_W-1:0] c;

        // Empty line; escapes of s, t and another byte, ending right after a backslash;
        // quote and backslash inside a plain argument, an empty quoted argument, an
        // argument that follows a closing quote directly, and a line closing an argument.
        line_bytes = '{CHAR_NUL,
                       CHAR_SPACE, 8'h0B, CHAR_QUOTE, 8'h78, CHAR_BSLASH, CHAR_S,
                       CHAR_BSLASH, CHAR_T, CHAR_BSLASH, 8'h71, CHAR_BSLASH, CHAR_NUL,
                       8'hFF, 8'h01, CHAR_QUOTE, CHAR_BSLASH, CHAR_CR, CHAR_QUOTE,
                       CHAR_QUOTE, 8'h7A, CHAR_TAB, 8'h0C, 8'h80, CHAR_NUL};

        repeat (2) @(negedge i_clk);
        rst_n <= 1'b1;
        foreach (line_bytes[k]) send_byte(line_bytes[k]);

        while (items_sent < ITEMS) begin
            line_bytes.delete();
            sender_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 24)) begin
                    case ($urandom_range(0, 3))
                        0: c = CHAR_QUOTE;
                        1: c = CHAR_BSLASH;
                        default: c = BYTE_W'($urandom_range(1, 255));
                    endcase
                    line_bytes.push_back(c);
                end
            end else begin
                n_args  = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 70)
                                                       : $urandom_range(0, 6);
                max_len = (n_args > 8) ? 2 : 6;
                repeat ($urandom_range(0, 2)) line_bytes.push_back(blank_byte());
                for (int a = 0; a < n_args; a++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        line_bytes.push_back(CHAR_QUOTE);
                        repeat ($urandom_range(0, max_len)) begin
                            if ($urandom_range(0, 3) == 0) begin
                                line_bytes.push_back(CHAR_BSLASH);
                                case ($urandom_range(0, 2))
                                    0: c = CHAR_S;
                                    1: c = CHAR_T;
                                    default: c = BYTE_W'($urandom_range(1, 255));
                                endcase
                            end else begin
                                do begin
                                    c = BYTE_W'($urandom_range(1, 255));
                                end while (c == CHAR_QUOTE || c == CHAR_BSLASH);
                            end
                            line_bytes.push_back(c);
                        end
                        line_bytes.push_back(CHAR_QUOTE);
                        repeat ($urandom_range(0, 1)) line_bytes.push_back(blank_byte());
                    end else begin
                        line_bytes.push_back(arg_byte(1'b1));
                        repeat ($urandom_range(0, max_len - 1)) begin
                            line_bytes.push_back(arg_byte(1'b0));
                        end
                        if (a < n_args - 1 || $urandom_range(0, 1) == 1) begin
                            line_bytes.push_back(blank_byte());
                        end
                    end
                end
                if ($urandom_range(0, 7) == 0 && line_bytes.size() > 0) begin
                    cut = $urandom_range(0, line_bytes.size() - 1);
                    while (line_bytes.size() > cut) void'(line_bytes.pop_back());
                end
            end
            line_bytes.push_back(CHAR_NUL);
            foreach (line_bytes[k]) send_byte(line_bytes[k]);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Fed %0d line bytes; checked %0d results over %0d lines.",
                 items_sent, results, lines);
        $display("Lines that dropped arguments past the cap of %0d: %0d.",
                 MAX_ARGS, capped_lines);
        if (mismatches == 0) begin
            $display("quoted_argument_tokenizer_test: PASS");
        end else begin
            $display("quoted_argument_tokenizer_test: FAIL");
        end
        $finish;
    end

endmodule
